/* sv/mmib_pkg.sv */
// shared types and constants for the mmib mutual information pipeline
package mmib_pkg;

    // modulation codes
    typedef enum logic [1:0] {
        MODE_QPSK  = 2'd0,
        MODE_16QAM = 2'd1,
        MODE_64QAM = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // configuration register indexes
    typedef enum logic {
        CFG_MIN_SINR = 1'b0,
        CFG_MAX_SINR = 1'b1
    } cfg_idx_t;

    localparam int XW       = 23;   // j argument width, q7.16
    localparam int JW       = 17;   // j result width, 0..65536
    localparam int LANE_LAT = 28;   // register stages inside one j lane

    // reciprocals ceil(2^34 / i), exact floor division for dividends below 2^31
    localparam int RECIP_SHIFT = 34;
    localparam logic [34:0] RECIP [0:8] = '{
        35'd0,
        35'd17179869184,
        35'd8589934592,
        35'd5726623062,
        35'd4294967296,
        35'd3435973837,
        35'd2863311531,
        35'd2454267027,
        35'd2147483648
    };

endpackage

/* sv/mmib_j_lane.sv */
// pipelined evaluation of the piecewise j approximation for one argument
module mmib_j_lane
    import mmib_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [XW-1:0] x_in,
    input  logic          cap_in,
    output logic [JW-1:0] j_out
);

    typedef struct packed {
        logic          cap;
        logic          low;
        logic          hz;
        logic          kbig;
        logic [4:0]    k;
        logic [JW-1:0] jl;
    } side_t;

    localparam logic [XW-1:0] X_SPLIT = 23'd107237;

    // powers of x
    logic [XW-1:0] p1_x_reg, p2_x_reg, p3_x_reg, p4_x_reg;
    logic          p1_cap_reg, p2_cap_reg, p3_cap_reg, p4_cap_reg;
    logic [45:0]   p1_xx_reg, p1_xx_next;
    logic [30:0]   p2_x2_reg, p2_x2_next, p3_x2_reg, p4_x2_reg;
    logic [53:0]   p3_x2x_reg, p3_x2x_next;
    logic [38:0]   p4_x3_reg, p4_x3_next;

    assign p1_xx_next  = 46'(x_in) * 46'(x_in);
    assign p2_x2_next  = 31'((47'(p1_xx_reg) + 47'd32768) >> 16);
    assign p3_x2x_next = 54'(p2_x2_reg) * 54'(p2_x_reg);
    assign p4_x3_next  = 39'((55'(p3_x2x_reg) + 55'd32768) >> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_x_reg   <= x_in;
            p1_cap_reg <= cap_in;
            p1_xx_reg  <= p1_xx_next;
            p2_x_reg   <= p1_x_reg;
            p2_cap_reg <= p1_cap_reg;
            p2_x2_reg  <= p2_x2_next;
            p3_x_reg   <= p2_x_reg;
            p3_cap_reg <= p2_cap_reg;
            p3_x2_reg  <= p2_x2_reg;
            p3_x2x_reg <= p3_x2x_next;
            p4_x_reg   <= p3_x_reg;
            p4_cap_reg <= p3_cap_reg;
            p4_x2_reg  <= p3_x2_reg;
            p4_x3_reg  <= p4_x3_next;
        end
    end

    // coefficient products, q20 coefficients
    logic [55:0] q_a_reg, q_b_reg, q_c_reg, q_d_reg, q_e_reg, q_g_reg;
    logic [55:0] q_a_next, q_b_next, q_c_next, q_d_next, q_e_next, q_g_next;
    logic        q_low_reg, q_low_next, q_cap_reg;

    always_comb
    begin
        q_a_next   = 56'd219417 * 56'(p4_x2_reg);
        q_b_next   = 56'd44152 * 56'(p4_x3_reg);
        q_c_next   = 56'd6712 * 56'(p4_x_reg);
        q_d_next   = 56'd1903 * 56'(p4_x3_reg);
        q_e_next   = 56'd149606 * 56'(p4_x2_reg);
        q_g_next   = 56'd86199 * 56'(p4_x_reg);
        q_low_next = p4_x_reg < X_SPLIT;
    end

    // polynomial sums
    logic [55:0] s1_a_reg, s1_lneg_reg, s1_hpos_reg, s1_hneg_reg;
    logic [55:0] s1_lneg_next, s1_hpos_next, s1_hneg_next;
    logic        s1_low_reg, s1_cap_reg;

    always_comb
    begin
        s1_lneg_next = q_b_reg + q_c_reg;
        s1_hpos_next = q_d_reg + (56'd57631 << 16);
        s1_hneg_next = q_e_reg + q_g_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_a_reg     <= q_a_next;
            q_b_reg     <= q_b_next;
            q_c_reg     <= q_c_next;
            q_d_reg     <= q_d_next;
            q_e_reg     <= q_e_next;
            q_g_reg     <= q_g_next;
            q_low_reg   <= q_low_next;
            q_cap_reg   <= p4_cap_reg;
            s1_a_reg    <= q_a_reg;
            s1_lneg_reg <= s1_lneg_next;
            s1_hpos_reg <= s1_hpos_next;
            s1_hneg_reg <= s1_hneg_next;
            s1_low_reg  <= q_low_reg;
            s1_cap_reg  <= q_cap_reg;
        end
    end

    // low branch result and exponent magnitude
    logic [30:0] s2_t_reg, s2_t_next;
    side_t       s2_side_reg, s2_side_next;
    logic [55:0] lo_diff, lo_v, hi_diff;

    always_comb
    begin
        lo_diff      = s1_a_reg - s1_lneg_reg;
        lo_v         = (lo_diff + 56'd524288) >> 20;
        hi_diff      = s1_hneg_reg - s1_hpos_reg;
        s2_t_next    = 31'((hi_diff + 56'd524288) >> 20);
        s2_side_next = '0;
        s2_side_next.cap = s1_cap_reg;
        s2_side_next.low = s1_low_reg;
        s2_side_next.hz  = s1_hpos_reg >= s1_hneg_reg;
        if (s1_a_reg <= s1_lneg_reg)
            s2_side_next.jl = '0;
        else if (lo_v > 56'd65536)
            s2_side_next.jl = JW'(65536);
        else
            s2_side_next.jl = lo_v[JW-1:0];
    end

    // exp setup: t * log2(e), split into integer and fraction, fraction * ln2
    logic [32:0] e1_u_reg, e1_u_next;
    logic [45:0] e2_yb_reg, e2_yb_next;
    logic [29:0] e3_y_reg;
    side_t       e1_side_reg, e2_side_reg, e2_side_next, e3_side_reg;

    always_comb
    begin
        e1_u_next    = 33'((49'(s2_t_reg) * 49'd94548 + 49'd32768) >> 16);
        e2_yb_next   = 46'(e1_u_reg[15:0]) * 46'd744261118;
        e2_side_next = e1_side_reg;
        e2_side_next.kbig = e1_u_reg[32:16] > 17'd30;
        e2_side_next.k    = e1_u_reg[20:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_t_reg    <= s2_t_next;
            s2_side_reg <= s2_side_next;
            e1_u_reg    <= e1_u_next;
            e1_side_reg <= s2_side_reg;
            e2_yb_reg   <= e2_yb_next;
            e2_side_reg <= e2_side_next;
            e3_y_reg    <= e2_yb_reg[45:16];
            e3_side_reg <= e2_side_reg;
        end
    end

    // taylor series of exp(-y), one multiply stage and one divide stage per term
    logic [30:0]        tm_n_reg    [1:8];
    logic [29:0]        tm_y_reg    [1:8];
    logic signed [33:0] tm_acc_reg  [1:8];
    side_t              tm_side_reg [1:8];
    logic [30:0]        td_term_reg [1:8];
    logic [29:0]        td_y_reg    [1:8];
    logic signed [33:0] td_acc_reg  [1:8];
    side_t              td_side_reg [1:8];

    for (genvar gi = 1; gi <= 8; gi++)
    begin : g_term
        logic [30:0]        term_in;
        logic [29:0]        y_in;
        logic signed [33:0] acc_in;
        side_t              side_in;
        logic [30:0]        n_next;
        logic [30:0]        term_next;
        logic signed [33:0] acc_next;

        if (gi == 1)
        begin : g_first
            assign term_in = 31'h4000_0000;
            assign y_in    = e3_y_reg;
            assign acc_in  = 34'sh4000_0000;
            assign side_in = e3_side_reg;
        end
        else
        begin : g_rest
            assign term_in = td_term_reg[gi-1];
            assign y_in    = td_y_reg[gi-1];
            assign side_in = td_side_reg[gi-1];
            // odd terms subtract
            if ((gi - 1) % 2 == 1)
            begin : g_sub
                assign acc_in = td_acc_reg[gi-1] - $signed(34'(td_term_reg[gi-1]));
            end
            else
            begin : g_add
                assign acc_in = td_acc_reg[gi-1] + $signed(34'(td_term_reg[gi-1]));
            end
        end

        assign n_next    = 31'((61'(term_in) * 61'(y_in)) >> 30);
        assign term_next = 31'((66'(tm_n_reg[gi]) * 66'(RECIP[gi])) >> RECIP_SHIFT);
        assign acc_next  = acc_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tm_n_reg[gi]    <= n_next;
                tm_y_reg[gi]    <= y_in;
                tm_acc_reg[gi]  <= acc_next;
                tm_side_reg[gi] <= side_in;
                td_term_reg[gi] <= term_next;
                td_y_reg[gi]    <= tm_y_reg[gi];
                td_acc_reg[gi]  <= tm_acc_reg[gi];
                td_side_reg[gi] <= tm_side_reg[gi];
            end
        end
    end

    // final sum, scale by 2^-k, branch select
    logic [32:0]        f1_acc_reg, f1_acc_next;
    side_t              f1_side_reg;
    logic signed [33:0] acc_sum;
    logic [JW-1:0]      j_reg, j_next;
    logic [5:0]         shamt;
    logic [45:0]        e_w;

    always_comb
    begin
        acc_sum     = td_acc_reg[8] + $signed(34'(td_term_reg[8]));
        f1_acc_next = acc_sum[33] ? '0 : acc_sum[32:0];
    end

    always_comb
    begin
        shamt = 6'd14 + 6'(f1_side_reg.k);
        e_w   = (46'(f1_acc_reg) + (46'd1 << (shamt - 6'd1))) >> shamt;
        if (f1_side_reg.cap)
            j_next = '0;
        else if (f1_side_reg.low)
            j_next = f1_side_reg.jl;
        else if (f1_side_reg.hz)
            j_next = '0;
        else if (f1_side_reg.kbig)
            j_next = JW'(65536);
        else
            j_next = JW'(65536) - e_w[JW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_acc_reg  <= f1_acc_next;
            f1_side_reg <= td_side_reg[8];
            j_reg       <= j_next;
        end
    end

    assign j_out = j_reg;

endmodule

/* sv/mmib_sinr_to_mutual_info.sv */
// mmib forward mapping: linear sinr and modulation to mean mutual information per bit
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  config   | cfg_wr_en, cfg_index, cfg_data            | in
//  input    | in_valid, in_ready, sinr_linear, mode     | in
//  output   | out_valid, out_ready, mutual_info, bad_mode| out
//
// one transfer per cycle in and out while the output is not stalled; RW + 33 register
// stages, where RW is the root width (21 at 16 sinr fraction bits): the input clamp,
// the one-bit-per-stage square root, the gain stages, the 28-stage j lanes and
// the weighting stages.
// reset clears the valid line and loads the default clamp limits.
// a stall at the output holds the whole pipeline in place; in_ready follows
// out_ready whenever the output register is full.
module mmib_sinr_to_mutual_info
    import mmib_pkg::*;
#(
    parameter int SINR_FRAC_BITS = 16,
    parameter int MI_FRAC_BITS   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [24:0] sinr_linear,
    input  logic [1:0]  mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] mutual_info,
    output logic        bad_mode
);

    // square root of the sinr scaled to q16 root
    localparam int SH   = 32 - SINR_FRAC_BITS;
    localparam int VW   = 25 + SH;
    localparam int RW   = (VW + 1) / 2;
    localparam int PADW = 2 * RW;
    localparam int GPW  = 18 + RW;
    localparam int XFW  = (RW + 3 > XW + 1) ? RW + 3 : XW + 1;

    // pipeline indexes: 0 input, 1..RW root, RW+1..RW+2 gain, lanes, two weighting stages
    localparam int LI  = RW + 2 + LANE_LAT;
    localparam int NST = LI + 3;

    // output scaling
    localparam int UP  = (MI_FRAC_BITS > 16) ? MI_FRAC_BITS - 16 : 0;
    localparam int DN  = (MI_FRAC_BITS < 16) ? 16 - MI_FRAC_BITS : 0;
    localparam int RND = (DN > 0) ? (1 << (DN - 1)) : 0;
    localparam logic [25:0] LIM = (MI_FRAC_BITS < 16) ?
                                  26'((1 << MI_FRAC_BITS) - 1) : 26'd65535;

    // q16 gains per lane and modulation
    localparam logic [17:0] GAIN [0:2][0:3] = '{
        '{18'd131072, 18'd52429,  18'd96338, 18'd0},
        '{18'd0,      18'd142213, 18'd34669, 18'd0},
        '{18'd0,      18'd63242,  18'd23986, 18'd0}
    };

    logic en;

    // configuration registers
    logic [24:0] min_sinr_reg, max_sinr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sinr_reg <= 25'd2072;
            max_sinr_reg <= 25'd20724305;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_SINR: min_sinr_reg <= cfg_data;
                CFG_MAX_SINR: max_sinr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid and mode travel alongside the data
    logic [NST-1:0] vld_reg, vld_next;
    mode_t          md_reg  [0:NST-1];

    assign en        = !vld_reg[NST-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NST-1];

    always_comb
    begin
        vld_next = {vld_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_reg[0] <= mode_t'(mode);
            for (int i = 1; i < NST; i++)
                md_reg[i] <= md_reg[i-1];
        end
    end

    // clamp at the input: max first, then min
    logic [24:0] s0_reg, s0_next, s_hi;

    always_comb
    begin
        s_hi    = (sinr_linear > max_sinr_reg) ? max_sinr_reg : sinr_linear;
        s0_next = (s_hi < min_sinr_reg) ? min_sinr_reg : s_hi;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_reg <= s0_next;
    end

    // restoring square root, one result bit per stage
    logic [RW+1:0]   sq_rem_reg  [1:RW];
    logic [RW-1:0]   sq_root_reg [1:RW];
    logic [PADW-1:0] sq_v_reg    [1:RW];

    for (genvar gj = 1; gj <= RW; gj++)
    begin : g_sq
        logic [RW+1:0]   rem_in, cat, trial, rem_next;
        logic [RW-1:0]   root_in, root_next;
        logic [PADW-1:0] v_in, v_next;
        logic            ge;

        if (gj == 1)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = PADW'({s0_reg, {SH{1'b0}}});
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[gj-1];
            assign root_in = sq_root_reg[gj-1];
            assign v_in    = sq_v_reg[gj-1];
        end

        always_comb
        begin
            cat       = {rem_in[RW-1:0], v_in[PADW-1 -: 2]};
            trial     = {root_in, 2'b01};
            ge        = cat >= trial;
            rem_next  = ge ? cat - trial : cat;
            root_next = {root_in[RW-2:0], ge};
            v_next    = v_in << 2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[gj]  <= rem_next;
                sq_root_reg[gj] <= root_next;
                sq_v_reg[gj]    <= v_next;
            end
        end
    end

    // j arguments: gain times root, rounded to q16, capped where j is zero anyway
    logic [GPW-1:0] gp_reg  [0:2];
    logic [XW-1:0]  x_reg   [0:2];
    logic           cap_reg [0:2];
    logic [JW-1:0]  j_w     [0:2];

    for (genvar gl = 0; gl < 3; gl++)
    begin : g_lane
        logic [GPW-1:0] gp_next;
        logic [GPW:0]   gp_rnd;
        logic [XFW-1:0] xf;

        always_comb
        begin
            gp_next = GPW'(GAIN[gl][md_reg[RW]]) * GPW'(sq_root_reg[RW]);
            gp_rnd  = {1'b0, gp_reg[gl]} + (GPW+1)'(32768);
            xf      = XFW'(gp_rnd >> 16);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                gp_reg[gl]  <= gp_next;
                x_reg[gl]   <= xf[XW-1:0];
                cap_reg[gl] <= |xf[XFW-1:XW];
            end
        end

        mmib_j_lane u_lane (
            .clk    (clk),
            .en     (en),
            .x_in   (x_reg[gl]),
            .cap_in (cap_reg[gl]),
            .j_out  (j_w[gl])
        );
    end

    // modulation weighting
    logic [18:0] c1_reg, c1_next;
    logic [18:0] jsum3;

    always_comb
    begin
        jsum3 = 19'(j_w[0]) + 19'(j_w[1]) + 19'(j_w[2]);
        case (md_reg[LI])
            MODE_QPSK:  c1_next = 19'(j_w[0]);
            MODE_16QAM: c1_next = (jsum3 + 19'(j_w[0]) + 19'd2) >> 2;
            default:    c1_next = jsum3 + 19'd1;
        endcase
    end

    // divide by three for 64qam, scale, saturate
    logic [15:0] mi_reg, mi_next;
    logic        bad_reg, bad_next;
    logic [53:0] c_prod;
    logic [18:0] c_q;
    logic [25:0] mi_w;

    always_comb
    begin
        c_prod = 54'(c1_reg) * 54'(RECIP[3]);
        if (md_reg[LI+1] == MODE_64QAM)
            c_q = 19'(c_prod >> RECIP_SHIFT);
        else
            c_q = c1_reg;
        mi_w = ((26'(c_q) + 26'(RND)) >> DN) << UP;
        if (mi_w > LIM)
            mi_w = LIM;
        bad_next = md_reg[LI+1] == MODE_NONE;
        mi_next  = bad_next ? '0 : mi_w[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg  <= c1_next;
            mi_reg  <= mi_next;
            bad_reg <= bad_next;
        end
    end

    assign mutual_info = mi_reg;
    assign bad_mode    = bad_reg;

endmodule
